[rtl/bse_pkg.sv]
// Shared types, constants and the log2 mantissa table for the Burning Ship
// smooth escape block. No dependencies; every other file imports it.
package bse_pkg;

  localparam int FRAC_BITS      = 32;
  localparam int MAX_ITER       = 64;
  localparam int LOG_TABLE_BITS = 8;

  localparam int IT_W      = 7;                  // holds 0..MAX_ITER
  localparam int OP_W      = 64;                 // multiplier operand width
  localparam int DIG_W     = 16;                 // operand digit per cell
  localparam int NUM_CELLS = OP_W / DIG_W;
  localparam int PROD_W    = 2 * OP_W;
  localparam int CNT_W     = 3;
  localparam int MUL_LAST  = NUM_CELLS + 2;      // last product leaves the row
  localparam int LOG_W     = 25;                 // signed Q.16 log2 result
  localparam int P_W       = $clog2(PROD_W);
  localparam int DIV_W     = 40;                 // dividend / quotient width
  localparam int DVS_W     = 23;                 // divisor width

  localparam logic [63:0] SAT_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {MT_R2, MT_SR, MT_SI, MT_SX} mtag_t;

  typedef struct packed {
    logic              vld;
    mtag_t             tag;
    logic [OP_W-1:0]   a;
    logic [OP_W-1:0]   b;
    logic [PROD_W-1:0] acc;
  } mlink_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_MUL, ST_TEST, ST_LOGZ, ST_LOGR,
    ST_DIVR, ST_LOGQ, ST_SCALE, ST_DIVQ, ST_DONE
  } st_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_REAL, CFG_ORIGIN_IMAG, CFG_STEP_REAL, CFG_STEP_IMAG,
    CFG_ESCAPE_RADIUS, CFG_MAX_ITERATIONS, CFG_COLOR_SCALE
  } cfg_idx_t;

  typedef logic [15:0] rom_t [2**LOG_TABLE_BITS];

  // log2(1 + i/2^LOG_TABLE_BITS) in Q.16, one bit per repeated squaring
  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] x;
    logic [15:0] r;
    for (int i = 0; i < 2**LOG_TABLE_BITS; i++) begin
      x = 64'((2**LOG_TABLE_BITS) + i) << (31 - LOG_TABLE_BITS);
      r = '0;
      for (int b = 0; b < 16; b++) begin
        x = (x * x) >> 31;
        r = {r[14:0], 1'b0};
        if (x >= 64'h1_0000_0000) begin
          x    = x >> 1;
          r[0] = 1'b1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

endpackage

[rtl/bse_mul_cell.sv]
// One cell of the multiplier row: folds the top operand digit into the
// running product and hands it on. Depends on bse_pkg.
module bse_mul_cell import bse_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  mlink_t lnk_i,
  output mlink_t lnk_o
);

  logic                    vld_r;
  mtag_t                   tag_r;
  logic [OP_W-1:0]         a_r;
  logic [OP_W-1:0]         b_r;
  logic [PROD_W-1:0]       acc_r;
  logic [OP_W+DIG_W-1:0]   part;
  logic [PROD_W-1:0]       acc_nxt;

  assign part    = lnk_i.a * lnk_i.b[OP_W-1 -: DIG_W];
  assign acc_nxt = (lnk_i.acc << DIG_W) + PROD_W'(part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= lnk_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= lnk_i.tag;
    a_r   <= lnk_i.a;
    b_r   <= lnk_i.b << DIG_W;
    acc_r <= acc_nxt;
  end

  assign lnk_o = '{vld: vld_r, tag: tag_r, a: a_r, b: b_r, acc: acc_r};

endmodule

[rtl/bse_log2.sv]
// Iterative log2 in Q.16: normalizes the operand a byte or a bit per cycle,
// then looks up the mantissa table. Depends on bse_pkg.
module bse_log2 import bse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [PROD_W-1:0]       x,
  input  logic [IT_W-1:0]         fb,
  output logic                    done,
  output logic signed [LOG_W-1:0] res
);

  logic                    busy_r;
  logic                    done_r;
  logic [PROD_W-1:0]       x_r;
  logic [P_W-1:0]          p_r;
  logic [IT_W-1:0]         fb_r;
  logic signed [LOG_W-1:0] res_r;
  logic [8:0]              pm;

  assign pm = {2'b00, p_r} - {2'b00, fb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && x_r[PROD_W-1]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= x;
      p_r  <= P_W'(PROD_W - 1);
      fb_r <= fb;
    end else if (busy_r) begin
      if (x_r[PROD_W-1]) begin
        res_r <= $signed({pm, LOG_ROM[x_r[PROD_W-2 -: LOG_TABLE_BITS]]});
      end else if (x_r[PROD_W-1 -: 8] == 8'd0) begin
        x_r <= x_r << 8;
        p_r <= p_r - P_W'(8);
      end else begin
        x_r <= x_r << 1;
        p_r <= p_r - P_W'(1);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

[rtl/bse_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bse_pkg for operand widths.
module bse_div import bse_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int DC_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [DC_W-1:0]  cnt_r;
  logic [DIV_W-1:0] num_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DC_W'(1);
        if (cnt_r == DC_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      num_r <= {num_r[DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

[rtl/burning_ship_smooth_escape.sv]
// Burning Ship smooth escape-time gray level, top level.
// Depends on bse_pkg, bse_mul_cell, bse_log2 and bse_div.
//
// One transaction on the in_ channel names a pixel (column, row); one
// transaction on the out_ channel returns its gray level. Pixels are handled
// one at a time: in_stall is high from acceptance until the result has been
// moved to the output register, so the next pixel can enter while that
// result still waits on a stalled receiver.
// Each round runs the two squares and the cross product through a row of
// NUM_CELLS multiply cells, 16 operand bits per cell, and tests escape.
// An escaping pixel adds up to three table log2 runs and up to two divides.
// The cfg_ port writes one register per cycle at cfg_idx; write only while
// the block is idle. Synchronous reset (rst_n low) restores the register
// defaults, empties the pipeline and drops any pending result.
module burning_ship_smooth_escape import bse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pixel_col,
  input  logic [11:0] in_pixel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_value,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [39:0] cfg_data
);

  // configuration
  logic signed [36:0] origin_real_r, origin_imag_r;
  logic signed [33:0] step_real_r, step_imag_r;
  logic [39:0]        escape_radius_r;
  logic [6:0]         max_iterations_r;
  logic [8:0]         color_scale_r;

  st_t st_r, st_nxt;
  logic kick_r;
  logic [CNT_W-1:0] cnt_r;

  logic [11:0]             col_r, row_r;
  logic signed [63:0]      cr_r, ci_r, zr_r, zi_r;
  logic [IT_W-1:0]         k_r, iters_r, iters_cap;
  logic [79:0]             r2_r;
  logic [PROD_W-1:0]       sr_r, si_r, sx_r, m_r;
  logic signed [LOG_W-1:0] lz_r, lr_r, lq_r;
  logic [DIV_W-1:0]        ratio_r;
  logic signed [35:0]      num_r;
  logic [7:0]              val_r;
  logic                    out_valid_r;
  logic [7:0]              out_val_r;

  logic signed [46:0] cprod_re, cprod_im;
  logic signed [63:0] cr_calc, ci_calc, zr_nxt, zi_nxt;
  logic [63:0]        ar, ai, sr_s, si_s, sx_s;
  logic [PROD_W-1:0]  m_sum, sr_sh, si_sh, sx_sh;
  logic               esc, last_rnd, lz_nonpos, num_pos, out_load;
  logic signed [25:0] v;
  logic signed [35:0] num_calc;

  mlink_t lnk [NUM_CELLS+1];

  logic                    log_start, log_done;
  logic [PROD_W-1:0]       log_x;
  logic [IT_W-1:0]         log_fb;
  logic signed [LOG_W-1:0] log_res;
  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_dvd, div_q;
  logic [DVS_W-1:0]        div_dvs;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r    <= -37'sd7730941133;
      origin_imag_r    <= -37'sd386547057;
      step_real_r      <= 34'sd1677722;
      step_imag_r      <= 34'sd1677722;
      escape_radius_r  <= 40'd214748364800;
      max_iterations_r <= 7'd50;
      color_scale_r    <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ORIGIN_REAL:    origin_real_r    <= cfg_data[36:0];
        CFG_ORIGIN_IMAG:    origin_imag_r    <= cfg_data[36:0];
        CFG_STEP_REAL:      step_real_r      <= cfg_data[33:0];
        CFG_STEP_IMAG:      step_imag_r      <= cfg_data[33:0];
        CFG_ESCAPE_RADIUS:  escape_radius_r  <= cfg_data;
        CFG_MAX_ITERATIONS: max_iterations_r <= cfg_data[6:0];
        CFG_COLOR_SCALE:    color_scale_r    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- datapath
  assign iters_cap = (max_iterations_r > IT_W'(MAX_ITER)) ? IT_W'(MAX_ITER)
                                                         : max_iterations_r;
  assign cprod_re  = step_real_r * $signed({1'b0, col_r});
  assign cprod_im  = step_imag_r * $signed({1'b0, row_r});
  assign cr_calc   = 64'(origin_real_r) + 64'(cprod_re);
  assign ci_calc   = 64'(origin_imag_r) + 64'(cprod_im);

  assign ar = zr_r[63] ? 64'(-zr_r) : 64'(zr_r);
  assign ai = zi_r[63] ? 64'(-zi_r) : 64'(zi_r);

  assign m_sum    = sr_r + si_r;
  assign esc      = m_sum > PROD_W'(r2_r);
  assign last_rnd = (k_r + IT_W'(1)) == iters_r;

  // truncate the fraction and saturate before adding c
  assign sr_sh  = sr_r >> FRAC_BITS;
  assign si_sh  = si_r >> FRAC_BITS;
  assign sx_sh  = sx_r >> (FRAC_BITS - 1);
  assign sr_s   = (|sr_sh[PROD_W-1:62]) ? SAT_LIMIT : sr_sh[63:0];
  assign si_s   = (|si_sh[PROD_W-1:62]) ? SAT_LIMIT : si_sh[63:0];
  assign sx_s   = (|sx_sh[PROD_W-1:62]) ? SAT_LIMIT : sx_sh[63:0];
  assign zr_nxt = $signed(sr_s) - $signed(si_s) + cr_r;
  assign zi_nxt = $signed(sx_s) + ci_r;

  assign lz_nonpos = lz_r[LOG_W-1] || (lz_r == '0);
  assign v         = $signed({3'b000, k_r, 16'h0000}) - 26'(lq_r);
  assign num_calc  = v * $signed({1'b0, color_scale_r});
  assign num_pos   = !num_r[35] && (num_r != '0);
  assign out_load  = (st_r == ST_DONE) && (!out_valid_r || !out_stall);

  // multiplier row
  always_comb begin
    lnk[0] = '{vld: 1'b0, tag: MT_R2, a: ar, b: ar, acc: '0};
    if (st_r == ST_INIT) begin
      lnk[0].vld = 1'b1;
      lnk[0].a   = 64'(escape_radius_r);
      lnk[0].b   = 64'(escape_radius_r);
    end else if (st_r == ST_MUL) begin
      case (cnt_r)
        CNT_W'(0): begin
          lnk[0].vld = 1'b1;
          lnk[0].tag = MT_SR;
        end
        CNT_W'(1): begin
          lnk[0].vld = 1'b1;
          lnk[0].tag = MT_SI;
          lnk[0].a   = ai;
          lnk[0].b   = ai;
        end
        CNT_W'(2): begin
          lnk[0].vld = 1'b1;
          lnk[0].tag = MT_SX;
          lnk[0].b   = ai;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    bse_mul_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .lnk_i (lnk[g]),
      .lnk_o (lnk[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (lnk[NUM_CELLS].vld) begin
      case (lnk[NUM_CELLS].tag)
        MT_R2:   r2_r <= lnk[NUM_CELLS].acc[79:0];
        MT_SR:   sr_r <= lnk[NUM_CELLS].acc;
        MT_SI:   si_r <= lnk[NUM_CELLS].acc;
        default: sx_r <= lnk[NUM_CELLS].acc;
      endcase
    end
  end

  bse_log2 u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .fb    (log_fb),
    .done  (log_done),
    .res   (log_res)
  );

  bse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  // ---------------------------------------------------------- next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_valid) st_nxt = ST_INIT;
      ST_INIT:  st_nxt = (iters_cap == '0) ? ST_DONE : ST_MUL;
      ST_MUL:   if (cnt_r == CNT_W'(MUL_LAST)) st_nxt = ST_TEST;
      ST_TEST: begin
        if (esc) st_nxt = ST_LOGZ;
        else if (last_rnd) st_nxt = ST_DONE;
        else st_nxt = ST_MUL;
      end
      ST_LOGZ:  if (log_done) st_nxt = (escape_radius_r == '0) ? ST_DIVR : ST_LOGR;
      ST_LOGR:  if (log_done) st_nxt = ST_DIVR;
      ST_DIVR:  if ((kick_r && lz_nonpos) || div_done) st_nxt = ST_LOGQ;
      ST_LOGQ:  if (log_done) st_nxt = ST_SCALE;
      ST_SCALE: st_nxt = ST_DIVQ;
      ST_DIVQ:  if ((kick_r && !num_pos) || div_done) st_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------- control outputs
  always_comb begin
    in_stall  = (st_r != ST_IDLE);
    log_start = kick_r && ((st_r == ST_LOGZ) || (st_r == ST_LOGR) || (st_r == ST_LOGQ));
    div_start = kick_r && (((st_r == ST_DIVR) && !lz_nonpos) ||
                           ((st_r == ST_DIVQ) && num_pos));
    log_x     = m_r;
    log_fb    = IT_W'(2 * FRAC_BITS);
    div_dvd   = {lz_r[23:0], 16'h0000};
    div_dvs   = {lr_r[DVS_W-2:0], 1'b0};
    unique case (st_r)
      ST_LOGR: begin
        log_x  = PROD_W'(escape_radius_r);
        log_fb = IT_W'(FRAC_BITS);
      end
      ST_LOGQ: begin
        log_x  = PROD_W'(ratio_r);
        log_fb = IT_W'(16);
      end
      ST_DIVQ: begin
        div_dvd = DIV_W'($unsigned(num_r)) + DIV_W'({iters_r, 15'h0000});
        div_dvs = {iters_r, 16'h0000};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      kick_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      kick_r <= (st_nxt != st_r);
      cnt_r  <= (st_r == ST_MUL) ? cnt_r + CNT_W'(1) : '0;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_val_r <= val_r;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          col_r <= in_pixel_col;
          row_r <= in_pixel_row;
        end
      end
      ST_INIT: begin
        cr_r    <= cr_calc;
        ci_r    <= ci_calc;
        zr_r    <= '0;
        zi_r    <= '0;
        k_r     <= '0;
        iters_r <= iters_cap;
        val_r   <= 8'd255;
      end
      ST_TEST: begin
        if (esc) begin
          m_r <= m_sum;
        end else begin
          zr_r <= zr_nxt;
          zi_r <= zi_nxt;
          k_r  <= k_r + IT_W'(1);
        end
      end
      ST_LOGZ: begin
        if (log_done) begin
          lz_r <= log_res;
          lr_r <= LOG_W'(1);
        end
      end
      ST_LOGR: begin
        // a radius whose log is below one LSB counts as one LSB
        if (log_done) lr_r <= (log_res[LOG_W-1] || log_res == '0) ? LOG_W'(1) : log_res;
      end
      ST_DIVR: begin
        if (kick_r && lz_nonpos) ratio_r <= DIV_W'(1);
        else if (div_done) ratio_r <= (div_q == '0) ? DIV_W'(1) : div_q;
      end
      ST_LOGQ:  if (log_done) lq_r <= log_res;
      ST_SCALE: num_r <= num_calc;
      ST_DIVQ: begin
        if (kick_r && !num_pos) val_r <= 8'd0;
        else if (div_done) val_r <= (|div_q[DIV_W-1:8]) ? 8'd255 : div_q[7:0];
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_val_r;

  // ------------------------------------------------------------ assertions
  a_test_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_TEST) |-> ($past(st_r) == ST_MUL))
    else $error("escape test entered without a multiply pass");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_TEST) |-> (k_r < iters_r))
    else $error("round count ran past the iteration limit");

  a_log_owner: assert property (@(posedge clk) disable iff (!rst_n)
    log_done |-> ((st_r == ST_LOGZ) || (st_r == ST_LOGR) || (st_r == ST_LOGQ)))
    else $error("log2 result arrived outside a log state");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((st_r == ST_DIVR) || (st_r == ST_DIVQ)))
    else $error("divider result arrived outside a divide state");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

endmodule

[tb/burning_ship_smooth_escape_tb.sv]
// Self-checking testbench for burning_ship_smooth_escape: random pixels under
// many register settings, checked against an in-bench fixed-point predictor.
// Depends on bse_pkg and the block's RTL only.
module burning_ship_smooth_escape_tb import bse_pkg::*;;

  localparam int  ITEMS_PER_VIEW = 48;
  localparam int  NUM_VIEWS      = 12;
  localparam int  CYCLE_LIMIT    = 6000000;
  localparam int  HOLD_CYCLES    = 4000;

  class shade_book;
    longint      org_re, org_im, stp_re, stp_im;
    logic [39:0] radius;
    logic [6:0]  max_it;
    logic [8:0]  scale;
    logic [7:0]  shade_q[$];
    int          errors, accepted, checked;

    function new();
      org_re = -64'sd7730941133;
      org_im = -64'sd386547057;
      stp_re = 64'sd1677722;
      stp_im = 64'sd1677722;
      radius = 40'd214748364800;
      max_it = 7'd50;
      scale  = 9'd256;
    endfunction

    function longint sx(logic [39:0] v, int w);
      logic [63:0] t;
      t = 64'(v) & ((64'd1 << w) - 64'd1);
      if (t[w-1]) t = t - (64'd1 << w);
      return longint'(t);
    endfunction

    function void write(cfg_idx_t idx, logic [39:0] v);
      case (idx)
        CFG_ORIGIN_REAL:    org_re = sx(v, 37);
        CFG_ORIGIN_IMAG:    org_im = sx(v, 37);
        CFG_STEP_REAL:      stp_re = sx(v, 34);
        CFG_STEP_IMAG:      stp_im = sx(v, 34);
        CFG_ESCAPE_RADIUS:  radius = v;
        CFG_MAX_ITERATIONS: max_it = v[6:0];
        CFG_COLOR_SCALE:    scale  = v[8:0];
        default: ;
      endcase
    endfunction

    // log2(1 + idx/256) in Q.16, one bit per squaring of a Q.31 mantissa
    function longint mant_log(logic [7:0] idx);
      logic [63:0] x;
      longint      r;
      x = (64'd256 + 64'(idx)) << 23;
      r = 0;
      for (int b = 0; b < 16; b++) begin
        x = (x * x) >> 31;
        r = r << 1;
        if (x >= 64'h1_0000_0000) begin
          x = x >> 1;
          r = r | 1;
        end
      end
      return r;
    endfunction

    function longint log2_fix(logic [127:0] x, int fb);
      int           p;
      logic [127:0] sh;
      p = 0;
      for (int i = 0; i < 128; i++) if (x[i]) p = i;
      if (p >= LOG_TABLE_BITS) sh = x >> (p - LOG_TABLE_BITS);
      else sh = x << (LOG_TABLE_BITS - p);
      return longint'(p - fb) * 65536 + mant_log(sh[7:0]);
    endfunction

    function logic [63:0] shift_sat(logic [127:0] x, int s);
      logic [127:0] t;
      t = x >> s;
      return (t > 128'(SAT_LIMIT)) ? SAT_LIMIT : t[63:0];
    endfunction

    function logic [7:0] shade_of(logic [11:0] col, logic [11:0] row);
      longint       cr, ci, zr, zi, lz, lr, ratio, lq, v, num, den, q, iters;
      logic [63:0]  ar, ai;
      logic [127:0] sr, si, m, r2;
      cr = org_re + stp_re * longint'({52'b0, col});
      ci = org_im + stp_im * longint'({52'b0, row});
      zr = 0;
      zi = 0;
      iters = (max_it < MAX_ITER) ? longint'(max_it) : MAX_ITER;
      r2 = 128'(radius) * 128'(radius);
      for (longint k = 0; k < iters; k++) begin
        ar = (zr < 0) ? -zr : zr;
        ai = (zi < 0) ? -zi : zi;
        sr = 128'(ar) * 128'(ar);
        si = 128'(ai) * 128'(ai);
        m  = sr + si;
        if (m > r2) begin
          lz = log2_fix(m, 2 * FRAC_BITS);
          lr = 1;
          if (radius != 0) begin
            lr = log2_fix(128'(radius), FRAC_BITS);
            if (lr < 1) lr = 1;
          end
          ratio = (lz * 65536) / (2 * lr);
          if (ratio < 1) ratio = 1;
          lq  = log2_fix(128'(ratio), 16);
          v   = k * 65536 - lq;
          num = v * longint'({55'b0, scale});
          if (num <= 0) return 8'd0;
          den = iters * 65536;
          q   = (num + den / 2) / den;
          return (q > 255) ? 8'd255 : q[7:0];
        end
        zr = longint'(shift_sat(sr, FRAC_BITS)) - longint'(shift_sat(si, FRAC_BITS)) + cr;
        zi = longint'(shift_sat(128'(ar) * 128'(ai), FRAC_BITS - 1)) + ci;
      end
      return 8'd255;
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row);
      shade_q.push_back(shade_of(col, row));
      accepted++;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_shade(logic [7:0] got);
      logic [7:0] want;
      checked++;
      if (shade_q.size() == 0) begin
        report($sformatf("unexpected pixel_value %0d", got));
        return;
      end
      want = shade_q.pop_front();
      if (got !== want)
        report($sformatf("pixel_value %0d, expected %0d (result %0d)", got, want, checked));
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [11:0] in_pixel_col, in_pixel_row;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel_value;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [39:0] cfg_data;

  shade_book book = new();
  int        cycles = 0;
  int        hold_left = 0;
  bit        held = 1'b0;
  bit        calm;

  burning_ship_smooth_escape dut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: check, random stalls, one long hold-off, timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[burning_ship_smooth_escape] ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) book.check_shade(out_pixel_value);
    if (!held && book.accepted >= 120) begin
      held      <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  task send_pixel(logic [11:0] col, logic [11:0] row);
    in_valid     <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_pixel(col, row);
    calm = (book.accepted >= 300 && book.accepted < 380);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.shade_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(cfg_idx_t idx, logic [39:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    book.write(idx, v);
  endtask

  task set_view(logic [39:0] ore, logic [39:0] oim, logic [39:0] sre, logic [39:0] sim,
                logic [39:0] rad, logic [39:0] mit, logic [39:0] scl);
    write_reg(CFG_ORIGIN_REAL, ore);
    write_reg(CFG_ORIGIN_IMAG, oim);
    write_reg(CFG_STEP_REAL, sre);
    write_reg(CFG_STEP_IMAG, sim);
    write_reg(CFG_ESCAPE_RADIUS, rad);
    write_reg(CFG_MAX_ITERATIONS, mit);
    write_reg(CFG_COLOR_SCALE, scl);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [39:0] rand40();
    return {8'($urandom_range(0, 255)), $urandom()};
  endfunction

  function automatic logic [39:0] signed_q(int lo_units, int hi_units);
    longint v;
    v = longint'($signed($urandom_range(0, hi_units - lo_units)) + lo_units) * 64'sd1073741824;
    v = v + longint'($urandom_range(0, 32'h3FFF_FFFF));
    return v[39:0];
  endfunction

  initial begin
    logic [39:0] sre, sim;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    calm         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view: corners, alternating bit patterns and one interior pixel
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2730, 12'd1365);
    send_pixel(12'd1365, 12'd2730);
    send_pixel(12'd300, 12'd2000);
    drain();
    // zero iterations
    set_view(40'hFE_3333_3333, 40'hFF_E8F5_C28F, 40'd1677722, 40'd1677722,
             40'd214748364800, 40'd0, 40'd256);
    send_pixel(12'd100, 12'd100);
    send_pixel(12'd4095, 12'd0);
    drain();
    // iteration cap, widest scale, smallest radius of zero
    set_view(40'hFE_3333_3333, 40'hFF_E8F5_C28F, 40'd4194304, 40'd4194304,
             40'd0, 40'd127, 40'd511);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2000, 12'd1900);
    send_pixel(12'd4095, 12'd4095);
    drain();
    // zero scale, sub-unit radius, one iteration
    set_view(40'h00_8000_0000, 40'h00_8000_0000, 40'd4194304, 40'd4194304,
             40'd1, 40'd1, 40'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();
    // register extremes: large positive and negative origins and steps, largest radius
    set_view(40'h08_0000_0000, 40'h17_FFFF_FFFF, 40'h1_0000_0000, 40'h2_FFFF_FFFF,
             40'hFF_FFFF_FFFF, 40'd64, 40'd256);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd4094);
    drain();
    set_view(40'h18_0000_0000, 40'h08_0000_0000, 40'h3_0000_0000, 40'h1_0000_0000,
             40'h02_0000_0000, 40'd64, 40'd256);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    for (int p = 0; p < NUM_VIEWS; p++) begin
      sre = 40'($urandom_range(1 << 18, 1 << 23));
      sim = 40'($urandom_range(1 << 18, 1 << 23));
      if ($urandom_range(0, 3) == 0) sre = -sre;
      if ($urandom_range(0, 3) == 0) sim = -sim;
      if (p == NUM_VIEWS - 1)
        set_view(rand40(), rand40(), rand40(), rand40(), rand40(), rand40(), rand40());
      else
        set_view(signed_q(-10, 4), signed_q(-8, 4), sre, sim,
                 {8'($urandom_range(2, 128)), $urandom()},
                 ($urandom_range(0, 4) == 0) ? 40'($urandom_range(25, 127))
                                             : 40'($urandom_range(1, 24)),
                 40'($urandom_range(0, 511)));
      for (int i = 0; i < ITEMS_PER_VIEW; i++)
        send_pixel(12'($urandom()), 12'($urandom()));
      drain();
    end

    $display("covered %0d pixels over %0d register views, %0d results checked",
             book.accepted, NUM_VIEWS + 6, book.checked);
    $display("including a %0d-cycle receiver hold-off and a stretch without gaps",
             HOLD_CYCLES);
    if (book.errors == 0 && book.shade_q.size() == 0) begin
      $display("[burning_ship_smooth_escape] OK");
    end else begin
      $display("[burning_ship_smooth_escape] ERROR");
    end
    $finish;
  end

endmodule
